// ----- design/nsmp_pkg.sv -----
// Package for the nibble-serial mouse port.
// Holds command codes, item structs and the delta clamp function; no dependencies.
package nsmp_pkg;

  localparam int POS_W      = 16;
  localparam int IN_POS_W   = 16;
  localparam int TMO_W      = 16;
  localparam int CNT_W      = 17;
  localparam int DELTA_W    = 8;
  localparam int IN_TDATA_W = 40;
  localparam int OUT_TDATA_W = 16;

  localparam logic [TMO_W-1:0]   TMO_RESET  = TMO_W'(232);
  localparam logic [CNT_W-1:0]   CNT_MAX    = {CNT_W{1'b1}};
  localparam logic [7:0]         PORT_PRESS = 8'hE0;
  localparam logic [7:0]         PORT_REL   = 8'hF0;

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_POS     = 3'd1,
    CMD_STB_RISE = 3'd2,
    CMD_STB_FALL = 3'd3,
    CMD_READ    = 3'd4
  } cmd_t;

  typedef struct packed {
    logic                left_pressed;
    logic [IN_POS_W-1:0] pos_y;
    logic [IN_POS_W-1:0] pos_x;
    logic [2:0]          command;
  } in_item_t;

  typedef struct packed {
    logic [1:0] phase_now;
    logic [7:0] port_value;
  } out_item_t;

  // Saturate a POS_W+1 bit signed difference to -128..127.
  function automatic logic [DELTA_W-1:0] clamp8(input logic signed [POS_W:0] v);
    logic [DELTA_W-1:0] r;
    if (v > (POS_W+1)'(signed'(127))) begin
      r = 8'h7F;
    end else if (v < -(POS_W+1)'(signed'(128))) begin
      r = 8'h80;
    end else begin
      r = v[DELTA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- design/nibble_serial_mouse_port.sv -----
// Nibble-serial mouse port, top level. Depends on nsmp_pkg and the nsmp_* stages.
// A read's result goes through the input register, then the result register, to the
// output. Throughput: one item per cycle, except that a read waits while the result
// register is full. Synchronous active-low reset clears all protocol state, sets
// timeout to 232 and empties both registers.
module nibble_serial_mouse_port
  import nsmp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [TMO_W-1:0]       cfg_wr_data,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [2:0] command, [18:3] pos_x, [34:19] pos_y, [35] left_pressed, [39:36] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [7:0] port_value, [9:8] phase_now, [15:10] zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic      advance;
  logic      item_valid;
  in_item_t  item;
  logic      out_free;
  logic      res_valid;
  out_item_t res;

  nsmp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  nsmp_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_valid  (item_valid),
    .item        (item),
    .out_free    (out_free),
    .advance     (advance),
    .res_valid   (res_valid),
    .res         (res)
  );

  nsmp_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_load   (res_valid),
    .res        (res),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- design/nsmp_in_stage.sv -----
// Input register of the mouse port: holds one accepted transfer.
// Depends on nsmp_pkg.
module nsmp_in_stage
  import nsmp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  advance,
  output logic                  item_valid,
  output in_item_t              item
);

  logic     valid_r;
  in_item_t item_r;

  assign in_tready  = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= in_item_t'(in_tdata[$bits(in_item_t)-1:0]);
    end
  end

endmodule

// ----- design/nsmp_core.sv -----
// Protocol state and read logic of the mouse port.
// Depends on nsmp_pkg; updates state on each consumed item.
module nsmp_core
  import nsmp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [TMO_W-1:0] cfg_wr_data,
  input  logic             item_valid,
  input  in_item_t         item,
  input  logic             out_free,
  output logic             advance,
  output logic             res_valid,
  output out_item_t        res
);

  logic [TMO_W-1:0]   tmo_r;
  logic [1:0]         phase_r, phase_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [POS_W-1:0]   cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [POS_W-1:0]   lat_x_r, lat_x_nxt, lat_y_r, lat_y_nxt;
  logic [DELTA_W-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic               left_r, left_nxt;

  cmd_t               cmd;
  logic               is_read;
  logic               fire;
  logic [DELTA_W-1:0] new_dx, new_dy;
  logic [3:0]         nib;

  assign cmd     = cmd_t'(item.command);
  assign is_read = (cmd == CMD_READ);
  assign advance = !item_valid || !is_read || out_free;
  assign fire    = item_valid && advance;

  assign new_dx = clamp8(signed'({lat_x_r[POS_W-1], lat_x_r})
                       - signed'({cur_x_r[POS_W-1], cur_x_r}));
  assign new_dy = clamp8(signed'({cur_y_r[POS_W-1], cur_y_r})
                       - signed'({lat_y_r[POS_W-1], lat_y_r}));

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    lat_x_nxt = lat_x_r;
    lat_y_nxt = lat_y_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    left_nxt  = left_r;
    res_valid = 1'b0;
    case (cmd)
      CMD_TICK: begin
        if (cnt_r != CNT_MAX) cnt_nxt = cnt_r + CNT_W'(1);
      end
      CMD_POS: begin
        cur_x_nxt = item.pos_x[POS_W-1:0];
        cur_y_nxt = item.pos_y[POS_W-1:0];
        left_nxt  = item.left_pressed;
      end
      CMD_STB_RISE: begin
        if (!phase_r[0]) phase_nxt = phase_r | 2'd1;
        cnt_nxt = '0;
      end
      CMD_STB_FALL: begin
        if (phase_r == 2'd1) begin
          phase_nxt = 2'd2;
        end else if (phase_r == 2'd3) begin
          phase_nxt = 2'd0;
          dx_nxt    = new_dx;
          dy_nxt    = new_dy;
          lat_x_nxt = cur_x_r;
          lat_y_nxt = cur_y_r;
        end
        cnt_nxt = '0;
      end
      CMD_READ: begin
        res_valid = item_valid;
        if (phase_r != 2'd0 && cnt_r > {1'b0, tmo_r}) begin
          phase_nxt = 2'd0;
          dx_nxt    = new_dx;
          dy_nxt    = new_dy;
          lat_x_nxt = cur_x_r;
          lat_y_nxt = cur_y_r;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    case (phase_nxt)
      2'd0:    nib = dx_nxt[7:4];
      2'd1:    nib = dx_nxt[3:0];
      2'd2:    nib = dy_nxt[7:4];
      default: nib = dy_nxt[3:0];
    endcase
    res.port_value = (left_r ? PORT_PRESS : PORT_REL) | {4'h0, nib};
    res.phase_now  = phase_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmo_r   <= TMO_RESET;
      phase_r <= '0;
      cnt_r   <= '0;
      cur_x_r <= '0;
      cur_y_r <= '0;
      lat_x_r <= '0;
      lat_y_r <= '0;
      dx_r    <= '0;
      dy_r    <= '0;
      left_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) tmo_r <= cfg_wr_data;
      if (fire) begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
        cur_x_r <= cur_x_nxt;
        cur_y_r <= cur_y_nxt;
        lat_x_r <= lat_x_nxt;
        lat_y_r <= lat_y_nxt;
        dx_r    <= dx_nxt;
        dy_r    <= dy_nxt;
        left_r  <= left_nxt;
      end
    end
  end

endmodule

// ----- design/nsmp_out_stage.sv -----
// Result register of the mouse port: holds one read result until transferred.
// Depends on nsmp_pkg.
module nsmp_out_stage
  import nsmp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   res_load,
  input  out_item_t              res,
  output logic                   out_free,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic      valid_r;
  out_item_t data_r;

  assign out_free   = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = OUT_TDATA_W'(data_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_free) begin
      valid_r <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_load) begin
      data_r <= res;
    end
  end

endmodule
